/* rtl/sle_pkg.sv */
package sle_pkg;

  typedef enum logic [1:0] {
    OP_INSERT = 2'd0,
    OP_DELETE = 2'd1,
    OP_GET    = 2'd2,
    OP_LOCATE = 2'd3
  } op_t;

  localparam int ELEM_W  = 8;
  localparam int POS_W   = 7;
  localparam int COUNT_W = 7;

  typedef struct packed {
    logic               ok;
    logic [ELEM_W-1:0]  element;
    logic [POS_W-1:0]   found_position;
    logic [COUNT_W-1:0] count;
    logic               is_empty;
  } res_t;

endpackage

/* rtl/sle_mem.sv */
module sle_mem #(
  parameter int DEPTH = 64,
  parameter int AW    = 6
) (
  input  logic                      clk,
  input  logic                      we,
  input  logic [AW-1:0]             waddr,
  input  logic [sle_pkg::ELEM_W-1:0] wdata,
  input  logic                      ren,
  input  logic [AW-1:0]             raddr,
  output logic [sle_pkg::ELEM_W-1:0] rdata
);
  import sle_pkg::*;

  logic [ELEM_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (ren) begin
      rdata <= mem[raddr];
    end
  end

endmodule

/* rtl/sle_ctrl.sv */
module sle_ctrl #(
  parameter int CAPACITY = 64,
  parameter int AW       = 6,
  parameter int CW       = 7
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       req_valid,
  output logic                       req_ready,
  input  logic [1:0]                 operation,
  input  logic [sle_pkg::POS_W-1:0]  position,
  input  logic [sle_pkg::ELEM_W-1:0] value,
  output logic                       res_valid,
  input  logic                       res_ready,
  output sle_pkg::res_t              res,
  output logic                       mem_we,
  output logic [AW-1:0]              mem_waddr,
  output logic [sle_pkg::ELEM_W-1:0] mem_wdata,
  output logic                       mem_ren,
  output logic [AW-1:0]              mem_raddr,
  input  logic [sle_pkg::ELEM_W-1:0] mem_rdata
);
  import sle_pkg::*;

  // compare width: holds count+1 and any position value
  localparam int XW = (CW > POS_W) ? CW + 1 : POS_W + 1;

  typedef enum logic [3:0] {
    S_IDLE  = 4'b0001,
    S_SCAN  = 4'b0010,
    S_STORE = 4'b0100,
    S_DONE  = 4'b1000
  } state_t;

  state_t            state, state_next;
  logic [CW-1:0]     cnt, cnt_next;
  op_t               op_r, op_next;
  logic [ELEM_W-1:0] val_r, val_next;
  logic [AW-1:0]     pos_m1, pos_m1_next;
  logic [AW-1:0]     addr, addr_next;
  logic [CW-1:0]     left, left_next;
  logic [AW-1:0]     prev, prev_next;
  logic              pend, pend_next;
  logic              first, first_next;
  logic              ok_r, ok_next;
  logic [ELEM_W-1:0] elem_r, elem_next;
  logic [CW-1:0]     found_r, found_next;

  logic [XW-1:0] pos_x, cnt_x;
  logic          pos_nz, ins_ok, rd_ok;
  logic [AW-1:0] req_pos_m1;
  logic          match, issue;

  assign pos_x      = XW'(position);
  assign cnt_x      = XW'(cnt);
  assign pos_nz     = (position != '0);
  assign ins_ok     = pos_nz && (pos_x <= cnt_x + XW'(1)) && (cnt_x != XW'(CAPACITY));
  assign rd_ok      = pos_nz && (pos_x <= cnt_x);
  assign req_pos_m1 = AW'(position - POS_W'(1));

  // shared compare: stored element against the search byte
  assign match = (state == S_SCAN) && pend && (op_r == OP_LOCATE) && (mem_rdata == val_r);
  assign issue = (state == S_SCAN) && (left != '0) && !match;

  assign req_ready = (state == S_IDLE);
  assign res_valid = (state == S_DONE);
  assign mem_ren   = issue;
  assign mem_raddr = addr;

  assign res.ok             = ok_r;
  assign res.element        = elem_r;
  assign res.found_position = POS_W'(found_r);
  assign res.count          = COUNT_W'(cnt);
  assign res.is_empty       = (cnt == '0);

  always_comb begin
    state_next  = state;
    cnt_next    = cnt;
    op_next     = op_r;
    val_next    = val_r;
    pos_m1_next = pos_m1;
    addr_next   = addr;
    left_next   = left;
    prev_next   = prev;
    pend_next   = pend;
    first_next  = first;
    ok_next     = ok_r;
    elem_next   = elem_r;
    found_next  = found_r;
    mem_we      = 1'b0;
    mem_waddr   = prev;
    mem_wdata   = mem_rdata;

    unique case (state)
      S_IDLE: begin
        if (req_valid) begin
          op_next     = op_t'(operation);
          val_next    = value;
          pos_m1_next = req_pos_m1;
          pend_next   = 1'b0;
          first_next  = 1'b1;
          elem_next   = '0;
          found_next  = '0;
          ok_next     = 1'b1;
          state_next  = S_SCAN;
          unique case (op_t'(operation))
            OP_INSERT: begin
              left_next = CW'(cnt_x + XW'(1) - pos_x);
              addr_next = AW'(cnt - CW'(1));
              if (!ins_ok) begin
                ok_next    = 1'b0;
                state_next = S_DONE;
              end
            end
            OP_DELETE: begin
              left_next = CW'(cnt_x + XW'(1) - pos_x);
              addr_next = req_pos_m1;
              if (!rd_ok) begin
                ok_next    = 1'b0;
                state_next = S_DONE;
              end
            end
            OP_GET: begin
              left_next = CW'(1);
              addr_next = req_pos_m1;
              if (!rd_ok) begin
                ok_next    = 1'b0;
                state_next = S_DONE;
              end
            end
            OP_LOCATE: begin
              left_next = cnt;
              addr_next = '0;
              ok_next   = 1'b0;
            end
            default: ;
          endcase
        end
      end

      S_SCAN: begin
        // read issued last cycle lands now; reads and writes overlap
        if (issue) begin
          addr_next = (op_r == OP_INSERT) ? addr - AW'(1) : addr + AW'(1);
          left_next = left - CW'(1);
          prev_next = addr;
        end
        pend_next = issue;
        if (pend) begin
          first_next = 1'b0;
          unique case (op_r)
            OP_INSERT: begin
              mem_we    = 1'b1;
              mem_waddr = prev + AW'(1);
            end
            OP_DELETE: begin
              if (first) begin
                elem_next = mem_rdata;
              end else begin
                mem_we    = 1'b1;
                mem_waddr = prev - AW'(1);
              end
            end
            OP_GET: begin
              elem_next = mem_rdata;
            end
            OP_LOCATE: begin
              if (match) begin
                ok_next    = 1'b1;
                found_next = CW'(prev) + CW'(1);
              end
            end
            default: ;
          endcase
        end
        if (match) begin
          state_next = S_DONE;
        end else if (left == '0) begin
          priority if (op_r == OP_INSERT) begin
            state_next = S_STORE;
          end else if (op_r == OP_DELETE) begin
            cnt_next   = cnt - CW'(1);
            state_next = S_DONE;
          end else begin
            state_next = S_DONE;
          end
        end
      end

      S_STORE: begin
        mem_we     = 1'b1;
        mem_waddr  = pos_m1;
        mem_wdata  = val_r;
        cnt_next   = cnt + CW'(1);
        state_next = S_DONE;
      end

      S_DONE: begin
        if (res_ready) begin
          state_next = S_IDLE;
        end
      end

      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      cnt   <= '0;
      pend  <= 1'b0;
    end else begin
      state <= state_next;
      cnt   <= cnt_next;
      pend  <= pend_next;
    end
  end

  always_ff @(posedge clk) begin
    op_r    <= op_next;
    val_r   <= val_next;
    pos_m1  <= pos_m1_next;
    addr    <= addr_next;
    left    <= left_next;
    prev    <= prev_next;
    first   <= first_next;
    ok_r    <= ok_next;
    elem_r  <= elem_next;
    found_r <= found_next;
  end

  a_cnt_bound: assert property (@(posedge clk) disable iff (rst)
    cnt <= CW'(CAPACITY))
    else $error("element count above capacity");

  a_we_state: assert property (@(posedge clk) disable iff (rst)
    mem_we |-> (state == S_SCAN || state == S_STORE))
    else $error("memory write outside scan or store");

  a_store_inc: assert property (@(posedge clk) disable iff (rst)
    (state == S_STORE) |=> (state == S_DONE) && (cnt == $past(cnt) + CW'(1)))
    else $error("insert did not grow the list by one");

  a_cnt_idle: assert property (@(posedge clk) disable iff (rst)
    (state == S_IDLE || state == S_DONE) |=> $stable(cnt) || $past(rst))
    else $error("count moved while no operation was running");

endmodule

/* rtl/sequential_list_engine_core.sv */
// Ordered list of up to CAPACITY bytes at 1-based positions, with insert, delete, get
// and locate requests; each request yields one response with ok, the element read or
// removed, the located position (0 when absent), and the count and empty flag after the
// request. Requests are taken one at a time through an element memory with one read port
// and one write port, so a shift reads one element and writes another in the same cycle.
// Delete reads the removed element and shifts later ones down; insert shifts from the
// position up, then stores the new byte; get reads one element; locate scans from
// position 1 and stops at the first hit; a rejected request goes straight to its
// response. The response sits in an output register, so the next request is taken
// while the previous response waits. No clearing pass after reset is needed.
module sequential_list_engine_core #(
  parameter int CAPACITY = 64
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       req_valid,
  output logic                       req_ready,
  input  logic [1:0]                 operation,
  input  logic [sle_pkg::POS_W-1:0]  position,
  input  logic [sle_pkg::ELEM_W-1:0] value,
  output logic                       rsp_valid,
  input  logic                       rsp_ready,
  output logic                       ok,
  output logic [sle_pkg::ELEM_W-1:0] element,
  output logic [sle_pkg::POS_W-1:0]  found_position,
  output logic [sle_pkg::COUNT_W-1:0] count,
  output logic                       is_empty
);
  import sle_pkg::*;

  localparam int AW = $clog2(CAPACITY);
  localparam int CW = $clog2(CAPACITY + 1);

  logic              res_valid, res_ready;
  res_t              res, rsp_q;
  logic              mem_we, mem_ren;
  logic [AW-1:0]     mem_waddr, mem_raddr;
  logic [ELEM_W-1:0] mem_wdata, mem_rdata;

  sle_ctrl #(
    .CAPACITY (CAPACITY),
    .AW       (AW),
    .CW       (CW)
  ) u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_ready (req_ready),
    .operation (operation),
    .position  (position),
    .value     (value),
    .res_valid (res_valid),
    .res_ready (res_ready),
    .res       (res),
    .mem_we    (mem_we),
    .mem_waddr (mem_waddr),
    .mem_wdata (mem_wdata),
    .mem_ren   (mem_ren),
    .mem_raddr (mem_raddr),
    .mem_rdata (mem_rdata)
  );

  sle_mem #(
    .DEPTH (CAPACITY),
    .AW    (AW)
  ) u_mem (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .ren   (mem_ren),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  // output register: load when empty or being drained this cycle
  assign res_ready = !rsp_valid || rsp_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (res_ready) begin
      rsp_valid <= res_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (res_ready && res_valid) begin
      rsp_q <= res;
    end
  end

  assign ok             = rsp_q.ok;
  assign element        = rsp_q.element;
  assign found_position = rsp_q.found_position;
  assign count          = rsp_q.count;
  assign is_empty       = rsp_q.is_empty;

endmodule
